>>> hdl/rpn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_pkg: shared types and constants for the RPN stack calculator
// Stack geometry, command and status codes, ALU handshake types and
// value conversion helpers.
// ----------------------------------------------------------------------------
package rpn_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int DATA_WIDTH  = 32;

    localparam int FIELD_W = 32;                        // width of value fields
    localparam int ADDR_W  = $clog2(STACK_DEPTH);
    localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
    localparam int ALU_CW  = $clog2(DATA_WIDTH);

    typedef logic [DATA_WIDTH-1:0] t_data;

    typedef enum logic [2:0] {
        CMD_PUSH  = 3'd0,
        CMD_ADD   = 3'd1,
        CMD_SUB   = 3'd2,
        CMD_MUL   = 3'd3,
        CMD_DIV   = 3'd4,
        CMD_PEEK  = 3'd5,
        CMD_CLEAR = 3'd6,
        CMD_DUMP  = 3'd7
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_UNDERFLOW = 3'd1,
        ST_FULL      = 3'd2,
        ST_DIVZERO   = 3'd3,
        ST_EMPTY     = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

    typedef struct packed {
        logic  done;
        t_data result;
    } t_alu_rsp;

    // sign-extend a 32-bit field, then wrap to the stack width
    function automatic t_data to_data(logic [FIELD_W-1:0] v);
        logic [63:0] ext;
        ext = {{(64-FIELD_W){v[FIELD_W-1]}}, v};
        return ext[DATA_WIDTH-1:0];
    endfunction

    // zero-extend / truncate a stack word to the 32-bit result field
    function automatic logic [FIELD_W-1:0] from_data(t_data d);
        logic [63:0] ext;
        ext = 64'(d);
        return ext[FIELD_W-1:0];
    endfunction

endpackage

>>> hdl/rpn_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_if: command and result channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface rpn_in_if;
    logic                 valid;
    logic                 ready;
    rpn_pkg::t_cmd        cmd;
    logic signed [31:0]   operand_value;

    modport source(output valid, output cmd, output operand_value, input ready);
    modport sink  (input valid, input cmd, input operand_value, output ready);
endinterface

interface rpn_out_if;
    logic                 valid;
    logic                 ready;
    logic signed [31:0]   result_value;
    rpn_pkg::t_status     status;
    logic                 last_item;

    modport source(output valid, output result_value, output status,
                   output last_item, input ready);
    modport sink  (input valid, input result_value, input status,
                   input last_item, output ready);
endinterface

>>> hdl/rpn_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_stack: operand store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rpn_stack (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [rpn_pkg::ADDR_W-1:0] i_waddr,
    input  rpn_pkg::t_data             i_wdata,
    input  logic [rpn_pkg::ADDR_W-1:0] i_raddr,
    output rpn_pkg::t_data             o_rdata
);

    rpn_pkg::t_data r_mem [rpn_pkg::STACK_DEPTH];
    rpn_pkg::t_data r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/rpn_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_alu: iterative arithmetic unit
// Add/sub in one step, shift-add multiply and restoring divide one bit
// per cycle, truncating signed quotient.
// ----------------------------------------------------------------------------
module rpn_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rpn_pkg::t_alu_req i_req,
    input  rpn_pkg::t_data    i_a,
    input  rpn_pkg::t_data    i_b,
    output rpn_pkg::t_alu_rsp o_rsp
);

    localparam int W = rpn_pkg::DATA_WIDTH;

    typedef enum logic [2:0] {
        A_IDLE,
        A_MUL,
        A_DIV,
        A_FIX,
        A_DONE
    } t_state;

    t_state                     r_state;
    rpn_pkg::t_data             r_acc;
    rpn_pkg::t_data             r_x;      // multiplicand / divisor magnitude
    rpn_pkg::t_data             r_y;      // multiplier / quotient
    rpn_pkg::t_data             r_rem;
    logic                       r_neg;
    logic [rpn_pkg::ALU_CW-1:0] r_cnt;

    logic [W:0]     div_shift;
    logic [W:0]     div_diff;
    rpn_pkg::t_data mag_a;
    rpn_pkg::t_data mag_b;

    always_comb begin
        div_shift = {r_rem, r_y[W-1]};
        div_diff  = div_shift - {1'b0, r_x};
        mag_a     = i_a[W-1] ? (W'(0) - i_a) : i_a;
        mag_b     = i_b[W-1] ? (W'(0) - i_b) : i_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
        end else begin
            unique case (r_state)
                A_IDLE: begin
                    if (i_req.start) begin
                        r_cnt <= rpn_pkg::ALU_CW'(W - 1);
                        unique case (i_req.op)
                            rpn_pkg::ALU_ADD: begin
                                r_acc   <= i_a + i_b;
                                r_state <= A_DONE;
                            end
                            rpn_pkg::ALU_SUB: begin
                                r_acc   <= i_a - i_b;
                                r_state <= A_DONE;
                            end
                            rpn_pkg::ALU_MUL: begin
                                r_acc   <= '0;
                                r_x     <= i_a;
                                r_y     <= i_b;
                                r_state <= A_MUL;
                            end
                            rpn_pkg::ALU_DIV: begin
                                r_rem   <= '0;
                                r_x     <= mag_b;
                                r_y     <= mag_a;
                                r_neg   <= i_a[W-1] ^ i_b[W-1];
                                r_state <= A_DIV;
                            end
                        endcase
                    end
                end
                A_MUL: begin
                    if (r_y[0]) begin
                        r_acc <= r_acc + r_x;
                    end
                    r_x   <= {r_x[W-2:0], 1'b0};
                    r_y   <= {1'b0, r_y[W-1:1]};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= A_DONE;
                    end
                end
                A_DIV: begin
                    if (!div_diff[W]) begin
                        r_rem <= div_diff[W-1:0];
                        r_y   <= {r_y[W-2:0], 1'b1};
                    end else begin
                        r_rem <= div_shift[W-1:0];
                        r_y   <= {r_y[W-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= A_FIX;
                    end
                end
                A_FIX: begin
                    r_acc   <= r_neg ? (W'(0) - r_y) : r_y;
                    r_state <= A_DONE;
                end
                A_DONE: begin
                    r_state <= A_IDLE;
                end
                default: begin
                    r_state <= A_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done   = (r_state == A_DONE);
    assign o_rsp.result = r_acc;

endmodule

>>> hdl/rpn_stack_calculator.sv
`timescale 1ns / 1ps
// Command timing: multiply and divide run on the one-bit-per-cycle shared ALU;
// a dump reads one entry at a time through the single read port and waits on
// output stalls. The next command is taken in the cycle after the last result
// beat is taken. Reset (synchronous, active low) empties the stack, returns the
// sequencer to idle and drops any pending result beat.
// ----------------------------------------------------------------------------
// rpn_stack_calculator: RPN integer calculator on a bounded stack
// Sequencer around a single-port-pair operand store and a shared
// iterative ALU; one result register on the output channel.
// ----------------------------------------------------------------------------
module rpn_stack_calculator (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rpn_in_if.sink    i_in,
    rpn_out_if.source o_out
);

    localparam int CW = rpn_pkg::CNT_W;
    localparam int AW = rpn_pkg::ADDR_W;

    typedef enum logic [2:0] {
        S_IDLE,     // waiting for a command
        S_RD_A,     // b on read data, fetching a
        S_OPS,      // a on read data, launch ALU or flag divide by zero
        S_ALU,      // ALU iterating
        S_PEEK,     // top on read data
        S_DUMP_RD,  // fetching next dump entry
        S_DUMP,     // dump entry on read data
        S_OUT       // result beat waiting
    } t_state;

    t_state              r_state;
    logic [CW-1:0]       r_count;
    logic [AW-1:0]       r_idx;
    logic                r_dump;
    rpn_pkg::t_alu_op    r_op;
    rpn_pkg::t_data      r_b;

    logic                r_out_valid;
    logic [31:0]         r_out_value;
    rpn_pkg::t_status    r_out_status;
    logic                r_out_last;

    logic                in_acc;
    logic                full;
    logic                below_two;
    logic                empty;
    logic                div_zero;
    logic [AW-1:0]       addr_top;
    logic [AW-1:0]       addr_next;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    rpn_pkg::t_data      mem_wdata;
    logic [AW-1:0]       mem_raddr;
    rpn_pkg::t_data      mem_rdata;

    rpn_pkg::t_alu_req   alu_req;
    rpn_pkg::t_alu_rsp   alu_rsp;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;

    assign full      = (r_count >= CW'(rpn_pkg::STACK_DEPTH));
    assign below_two = (r_count < CW'(2));
    assign empty     = (r_count == '0);
    assign div_zero  = (r_op == rpn_pkg::ALU_DIV) && (r_b == '0);
    assign addr_top  = AW'(r_count - CW'(1));
    assign addr_next = AW'(r_count - CW'(2));

    // Memory port steering: push writes at the accept edge, the ALU
    // result overwrites the second-from-top entry.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = AW'(r_count);
        mem_wdata = rpn_pkg::to_data(i_in.operand_value);
        if (in_acc && (i_in.cmd == rpn_pkg::CMD_PUSH) && !full) begin
            mem_we = 1'b1;
        end else if ((r_state == S_ALU) && alu_rsp.done) begin
            mem_we    = 1'b1;
            mem_waddr = addr_next;
            mem_wdata = alu_rsp.result;
        end
    end

    // Read address: top by default, so peek, the first dump entry and b are on the
    // read data in the cycle after the command is taken.
    always_comb begin
        unique case (r_state)
            S_RD_A:    mem_raddr = addr_next;
            S_DUMP_RD: mem_raddr = r_idx;
            default:   mem_raddr = addr_top;
        endcase
    end

    assign alu_req.start = (r_state == S_OPS) && !div_zero;
    assign alu_req.op    = r_op;

    rpn_stack u_stack (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    rpn_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .i_a     (mem_rdata),
        .i_b     (r_b),
        .o_rsp   (alu_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_dump      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_out_value  <= '0;
                        r_out_status <= rpn_pkg::ST_OK;
                        r_out_last   <= 1'b1;
                        unique case (i_in.cmd)
                            rpn_pkg::CMD_PUSH: begin
                                r_out_valid <= 1'b1;
                                r_state     <= S_OUT;
                                if (full) begin
                                    r_out_status <= rpn_pkg::ST_FULL;
                                end else begin
                                    r_count     <= r_count + 1'b1;
                                    r_out_value <= rpn_pkg::from_data(
                                        rpn_pkg::to_data(i_in.operand_value));
                                end
                            end
                            rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB,
                            rpn_pkg::CMD_MUL, rpn_pkg::CMD_DIV: begin
                                unique case (i_in.cmd)
                                    rpn_pkg::CMD_ADD: r_op <= rpn_pkg::ALU_ADD;
                                    rpn_pkg::CMD_SUB: r_op <= rpn_pkg::ALU_SUB;
                                    rpn_pkg::CMD_MUL: r_op <= rpn_pkg::ALU_MUL;
                                    default:          r_op <= rpn_pkg::ALU_DIV;
                                endcase
                                if (below_two) begin
                                    r_out_status <= rpn_pkg::ST_UNDERFLOW;
                                    r_out_valid  <= 1'b1;
                                    r_state      <= S_OUT;
                                end else begin
                                    r_state <= S_RD_A;
                                end
                            end
                            rpn_pkg::CMD_PEEK: begin
                                if (empty) begin
                                    r_out_status <= rpn_pkg::ST_EMPTY;
                                    r_out_valid  <= 1'b1;
                                    r_state      <= S_OUT;
                                end else begin
                                    r_state <= S_PEEK;
                                end
                            end
                            rpn_pkg::CMD_CLEAR: begin
                                r_count     <= '0;
                                r_out_valid <= 1'b1;
                                r_state     <= S_OUT;
                            end
                            rpn_pkg::CMD_DUMP: begin
                                if (empty) begin
                                    r_out_status <= rpn_pkg::ST_EMPTY;
                                    r_out_valid  <= 1'b1;
                                    r_state      <= S_OUT;
                                end else begin
                                    r_idx   <= addr_top;
                                    r_dump  <= 1'b1;
                                    r_state <= S_DUMP;
                                end
                            end
                        endcase
                    end
                end
                S_RD_A: begin
                    r_b     <= mem_rdata;
                    r_state <= S_OPS;
                end
                S_OPS: begin
                    if (div_zero) begin
                        r_out_status <= rpn_pkg::ST_DIVZERO;
                        r_out_valid  <= 1'b1;
                        r_state      <= S_OUT;
                    end else begin
                        r_state <= S_ALU;
                    end
                end
                S_ALU: begin
                    if (alu_rsp.done) begin
                        r_count     <= r_count - 1'b1;
                        r_out_value <= rpn_pkg::from_data(alu_rsp.result);
                        r_out_valid <= 1'b1;
                        r_state     <= S_OUT;
                    end
                end
                S_PEEK: begin
                    r_out_value <= rpn_pkg::from_data(mem_rdata);
                    r_out_valid <= 1'b1;
                    r_state     <= S_OUT;
                end
                S_DUMP_RD: begin
                    r_state <= S_DUMP;
                end
                S_DUMP: begin
                    r_out_value  <= rpn_pkg::from_data(mem_rdata);
                    r_out_status <= rpn_pkg::ST_OK;
                    r_out_last   <= (r_idx == '0);
                    r_out_valid  <= 1'b1;
                    r_state      <= S_OUT;
                end
                S_OUT: begin
                    if (o_out.ready) begin
                        r_out_valid <= 1'b0;
                        // walk down until the bottom entry has gone out
                        if (r_dump && (r_idx != '0)) begin
                            r_idx   <= r_idx - 1'b1;
                            r_state <= S_DUMP_RD;
                        end else begin
                            r_dump  <= 1'b0;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.result_value = r_out_value;
    assign o_out.status       = r_out_status;
    assign o_out.last_item    = r_out_last;

endmodule

>>> hdl/rpn_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_checker: port-level checks for the RPN calculator
// Watches both channels; bound to the top level.
// ----------------------------------------------------------------------------
module rpn_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [31:0]      i_out_value,
    input rpn_pkg::t_status i_out_status,
    input logic             i_out_last
);

    // a pending result beat holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result beat dropped while stalled");

    // one command at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("command taken while previous one in flight");

    // no new command while a result is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("ready raised with result pending");

    // errors end the command and carry a zero value
    a_error_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out_status != rpn_pkg::ST_OK))
            |-> (i_out_last && (i_out_value == '0)))
        else $error("error beat not final or value non-zero");

endmodule

bind rpn_stack_calculator rpn_checker u_rpn_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_value  (o_out.result_value),
    .i_out_status (o_out.status),
    .i_out_last   (o_out.last_item)
);

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for rpn_stack_calculator
// A table of directed commands, then random command streams (stack fills,
// well-formed expressions and raw noise). Each accepted command runs
// through an in-bench stack model; every result beat is checked in order.
// ----------------------------------------------------------------------------
module tb;
    import rpn_pkg::*;

    localparam int  TOTAL_ITEMS  = 470;          // the last episode runs a little past this
    localparam int  DRAIN_CYCLES = 48;           // beyond the longest ALU latency
    localparam int  MAX_REPORTS  = 10;
    localparam longint LIMIT_NS  = 64'd30_000_000;

    typedef struct packed {
        logic [31:0] value;
        t_status     status;
        logic        last;
    } t_result_beat;

    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] operand;
        logic        typed;                      // expected beat written in the row
        logic [31:0] value;
        t_status     status;
    } t_stim_row;

    typedef enum int { EP_FILL, EP_NOISE, EP_EXPR } t_episode;

    localparam int N_ROWS = 25;

    logic i_clk;
    logic i_rst_n;

    rpn_in_if  u_in ();
    rpn_out_if u_out ();

    rpn_stack_calculator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (u_in),
        .o_out   (u_out)
    );

    // stack model
    t_data        calc_stack [STACK_DEPTH];
    int           calc_depth;
    t_result_beat response_q [$];

    int           error_count;
    int           items_issued;
    int           in_burst;
    int           out_burst;
    int           out_hold;
    t_stim_row    directed_rows [N_ROWS];

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #(LIMIT_NS);
        $display("rpn_stack_calculator regression: fail");
        $finish;
    end

    // wait draw: a gap of random length per beat, with occasional stretches of back-to-back beats
    function automatic int draw_wait(inout int burst_left);
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            burst_left = $urandom_range(8, 30);
        return $urandom_range(0, 19);
    endfunction

    function automatic t_data trunc_quotient(t_data a, t_data b);
        t_data ma;
        t_data mb;
        t_data q;
        ma = a[DATA_WIDTH-1] ? -a : a;
        mb = b[DATA_WIDTH-1] ? -b : b;
        q  = ma / mb;
        return (a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1]) ? -q : q;
    endfunction

    // work out the beats a command produces and update the model stack
    function automatic void predict_beats(t_cmd c, logic [31:0] v);
        t_data a;
        t_data b;
        t_data r;
        case (c)
            CMD_PUSH: begin
                if (calc_depth >= STACK_DEPTH) begin
                    response_q.push_back('{32'd0, ST_FULL, 1'b1});
                end else begin
                    calc_stack[calc_depth] = v;
                    calc_depth++;
                    response_q.push_back('{v, ST_OK, 1'b1});
                end
            end
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
                if (calc_depth < 2) begin
                    response_q.push_back('{32'd0, ST_UNDERFLOW, 1'b1});
                end else begin
                    b = calc_stack[calc_depth-1];
                    a = calc_stack[calc_depth-2];
                    if (c == CMD_DIV && b == '0) begin
                        // divide by zero leaves both operands in place
                        response_q.push_back('{32'd0, ST_DIVZERO, 1'b1});
                    end else begin
                        case (c)
                            CMD_ADD: r = a + b;
                            CMD_SUB: r = a - b;
                            CMD_MUL: r = a * b;
                            default: r = trunc_quotient(a, b);
                        endcase
                        calc_depth--;
                        calc_stack[calc_depth-1] = r;
                        response_q.push_back('{r, ST_OK, 1'b1});
                    end
                end
            end
            CMD_PEEK: begin
                if (calc_depth == 0)
                    response_q.push_back('{32'd0, ST_EMPTY, 1'b1});
                else
                    response_q.push_back('{calc_stack[calc_depth-1], ST_OK, 1'b1});
            end
            CMD_CLEAR: begin
                calc_depth = 0;
                response_q.push_back('{32'd0, ST_OK, 1'b1});
            end
            CMD_DUMP: begin
                if (calc_depth == 0) begin
                    response_q.push_back('{32'd0, ST_EMPTY, 1'b1});
                end else begin
                    // top first, stack untouched
                    for (int i = 0; i < calc_depth; i++)
                        response_q.push_back('{calc_stack[calc_depth-1-i], ST_OK,
                                               (i + 1 == calc_depth)});
                end
            end
        endcase
    endfunction

    // one command beat; valid is only lowered when a gap is drawn
    task automatic issue_command(t_cmd c, logic [31:0] v, logic typed,
                                 logic [31:0] typed_val, t_status typed_st);
        int gap;
        gap = draw_wait(in_burst);
        if (gap > 0) begin
            u_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        u_in.valid         <= 1'b1;
        u_in.cmd           <= c;
        u_in.operand_value <= v;
        @(posedge i_clk);
        while (!u_in.ready) @(posedge i_clk);
        predict_beats(c, v);
        // hand-written rows always give a single beat
        if (typed)
            response_q[$] = '{typed_val, typed_st, 1'b1};
        items_issued++;
    endtask

    task automatic issue_random(t_cmd c, logic [31:0] v);
        issue_command(c, v, 1'b0, 32'd0, ST_OK);
    endtask

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h8000_0000;
            4:       return 32'h7FFF_FFFF;
            5:       return 32'($urandom_range(0, 40)) - 32'd20;
            default: return $urandom();
        endcase
    endfunction

    // mostly well-formed: push when the stack is shallow, reduce when deep
    function automatic t_cmd pick_command();
        int roll;
        roll = $urandom_range(0, 99);
        if (calc_depth < 2 && roll < 80)
            return CMD_PUSH;
        if (calc_depth >= 28 && roll < 70)
            return t_cmd'($urandom_range(CMD_ADD, CMD_DIV));
        if (roll < 45) return CMD_PUSH;
        if (roll < 85) return t_cmd'($urandom_range(CMD_ADD, CMD_DIV));
        if (roll < 91) return CMD_PEEK;
        if (roll < 97) return CMD_DUMP;
        return CMD_CLEAR;
    endfunction

    // hold the sender off until the block has nothing left to say
    task automatic drain_pause();
        u_in.valid <= 1'b0;
        @(posedge i_clk);
        while (response_q.size() != 0) @(posedge i_clk);
    endtask

    // result side: random stalls on ready, in-order check of every beat
    always @(posedge i_clk) begin
        t_result_beat got;
        t_result_beat want;
        int           w;
        if (!i_rst_n) begin
            u_out.ready <= 1'b0;
            out_hold = 0;
        end else if (u_out.valid && u_out.ready) begin
            got = '{u_out.result_value, u_out.status, u_out.last_item};
            if (response_q.size() == 0) begin
                if (error_count < MAX_REPORTS)
                    $display("%0t: unexpected result beat value=%h status=%0d last=%b",
                             $realtime, got.value, got.status, got.last);
                error_count++;
            end else begin
                want = response_q.pop_front();
                if (got.value !== want.value || got.status !== want.status ||
                    got.last !== want.last) begin
                    if (error_count < MAX_REPORTS)
                        $display("%0t: result mismatch value %h/%h status %0d/%0d last %b/%b",
                                 $realtime, want.value, got.value, want.status,
                                 got.status, want.last, got.last);
                    error_count++;
                end
            end
            w = draw_wait(out_burst);
            if (w > 0) begin
                u_out.ready <= 1'b0;
                out_hold = w - 1;
            end
        end else if (!u_out.ready) begin
            if (out_hold == 0)
                u_out.ready <= 1'b1;
            else
                out_hold--;
        end
    end

    initial begin
        t_episode ep;
        int       episode;
        int       extra;

        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        u_in.valid         = 1'b0;
        u_in.cmd           = CMD_PUSH;
        u_in.operand_value = '0;
        u_out.ready        = 1'b0;
        calc_depth         = 0;
        error_count        = 0;
        items_issued       = 0;
        in_burst           = 0;
        out_burst          = 0;
        out_hold           = 0;

        // empty-stack errors, wrap at the extremes, min / -1, divide by
        // zero, negative truncation, clear on an empty stack
        directed_rows = '{
            '{CMD_PEEK,  32'h1234_5678, 1'b1, 32'd0,        ST_EMPTY},
            '{CMD_DUMP,  32'hFFFF_FFFF, 1'b1, 32'd0,        ST_EMPTY},
            '{CMD_ADD,   32'd0,         1'b1, 32'd0,        ST_UNDERFLOW},
            '{CMD_CLEAR, 32'hA5A5_A5A5, 1'b1, 32'd0,        ST_OK},
            '{CMD_PUSH,  32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, ST_OK},
            '{CMD_MUL,   32'hFFFF_FFFF, 1'b1, 32'd0,        ST_UNDERFLOW},
            '{CMD_PUSH,  32'd1,         1'b1, 32'd1,        ST_OK},
            '{CMD_ADD,   32'd0,         1'b1, 32'h8000_0000, ST_OK},
            '{CMD_PUSH,  32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, ST_OK},
            '{CMD_DIV,   32'd0,         1'b1, 32'h8000_0000, ST_OK},
            '{CMD_PUSH,  32'd0,         1'b1, 32'd0,        ST_OK},
            '{CMD_DIV,   32'h5555_5555, 1'b1, 32'd0,        ST_DIVZERO},
            '{CMD_DUMP,  32'd0,         1'b0, 32'd0,        ST_OK},
            '{CMD_SUB,   32'd0,         1'b0, 32'd0,        ST_OK},
            '{CMD_PUSH,  32'hFFFF_FFF9, 1'b1, 32'hFFFF_FFF9, ST_OK},
            '{CMD_PUSH,  32'd2,         1'b1, 32'd2,        ST_OK},
            '{CMD_DIV,   32'd0,         1'b0, 32'd0,        ST_OK},
            '{CMD_MUL,   32'd0,         1'b0, 32'd0,        ST_OK},
            '{CMD_PUSH,  32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, ST_OK},
            '{CMD_SUB,   32'd0,         1'b0, 32'd0,        ST_OK},
            '{CMD_PUSH,  32'h5A5A_5A5A, 1'b1, 32'h5A5A_5A5A, ST_OK},
            '{CMD_PEEK,  32'd0,         1'b0, 32'd0,        ST_OK},
            '{CMD_DIV,   32'd0,         1'b0, 32'd0,        ST_OK},
            '{CMD_CLEAR, 32'd0,         1'b1, 32'd0,        ST_OK},
            '{CMD_PEEK,  32'd0,         1'b1, 32'd0,        ST_EMPTY}
        };

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r])
            issue_command(directed_rows[r].cmd, directed_rows[r].operand,
                          directed_rows[r].typed, directed_rows[r].value,
                          directed_rows[r].status);

        // random part; the first episode always fills the stack so that the
        // full-stack push and the longest dump are reached early
        episode = 0;
        while (items_issued < TOTAL_ITEMS) begin
            if (episode == 0 || $urandom_range(0, 9) == 0)
                ep = EP_FILL;
            else if ($urandom_range(0, 8) == 0)
                ep = EP_NOISE;
            else
                ep = EP_EXPR;

            case (ep)
                EP_FILL: begin
                    while (calc_depth < STACK_DEPTH)
                        issue_random(CMD_PUSH, pick_operand());
                    extra = $urandom_range(1, 2);
                    repeat (extra) issue_random(CMD_PUSH, pick_operand());
                    issue_random(CMD_DUMP, $urandom());
                end
                EP_NOISE: begin
                    repeat (10) issue_random(t_cmd'($urandom_range(0, 7)), $urandom());
                end
                default: begin
                    repeat (20) issue_random(pick_command(), pick_operand());
                end
            endcase

            // the first episode always drains, later ones now and then
            if (episode == 0 || $urandom_range(0, 3) == 0)
                drain_pause();
            episode++;
        end
        u_in.valid <= 1'b0;

        while (response_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("rpn_stack_calculator regression: pass");
        else
            $display("rpn_stack_calculator regression: fail");
        $finish;
    end

endmodule
